// ===== rtl/wstq_pkg.sv =====
`timescale 1ns / 1ps

package wstq_pkg;

  // Default geometry
  localparam int NUM_WORKER_QUEUES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF       = 256;

  // Ring number field, wide enough for the largest ring count (16 workers plus global)
  localparam int RING_IDX_W = 5;

  // Configuration port
  localparam int          APB_ADDR_W        = 3;
  localparam int          APB_DATA_W        = 32;
  localparam logic        REG_STEAL_TRIES   = 1'b0;
  localparam logic [2:0]  STEAL_TRIES_RESET = 3'd4;

  // Request operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_OWN    = 2'd1,
    SRC_GLOBAL = 2'd2,
    SRC_STOLEN = 2'd3
  } source_kind_e;

  typedef struct packed {
    logic        operation;
    logic [3:0]  queue_select;
    logic [2:0]  worker;
    logic [31:0] task_id;
  } req_t;

  typedef struct packed {
    logic         found;
    logic [31:0]  popped_id;
    source_kind_e source_kind;
    logic [3:0]   source_queue;
    logic         overflow;
  } rsp_t;

  // Pop source chosen from the ring occupancy
  typedef struct packed {
    logic                  found;
    source_kind_e          kind;
    logic [RING_IDX_W-1:0] ring;
  } pick_t;

endpackage

// ===== rtl/wstq_pick.sv =====
`timescale 1ns / 1ps

module wstq_pick #(
  parameter int NUM_WORKER_QUEUES = wstq_pkg::NUM_WORKER_QUEUES_DEF
) (
  input  logic [NUM_WORKER_QUEUES:0] nonempty_i,
  input  logic [2:0]                 worker_i,
  input  logic [2:0]                 steal_tries_i,
  output wstq_pkg::pick_t            pick_o
);

  localparam int NUM_RINGS = NUM_WORKER_QUEUES + 1;
  localparam int RW        = $clog2(NUM_RINGS);
  localparam int VW        = wstq_pkg::RING_IDX_W;

  logic [VW-1:0] wk;
  logic [VW-1:0] limit;

  // Fold the worker number into the worker range
  always_comb begin
    wk = VW'(worker_i);
    for (int i = 0; i < 4; i++) begin
      if (wk >= VW'(NUM_WORKER_QUEUES)) begin
        wk = wk - VW'(NUM_WORKER_QUEUES);
      end
    end
  end

  // Clamp the victim count to the other workers
  assign limit = (VW'(steal_tries_i) > VW'(NUM_WORKER_QUEUES - 1)) ?
                 VW'(NUM_WORKER_QUEUES - 1) : VW'(steal_tries_i);

  // Priority: own ring, global ring, then victims in rotating order
  always_comb begin
    logic [VW-1:0] v;
    pick_o       = '0;
    pick_o.kind  = wstq_pkg::SRC_NONE;
    v            = '0;
    if (nonempty_i[wk[RW-1:0]]) begin
      pick_o.found = 1'b1;
      pick_o.kind  = wstq_pkg::SRC_OWN;
      pick_o.ring  = wk;
    end else if (nonempty_i[NUM_WORKER_QUEUES]) begin
      pick_o.found = 1'b1;
      pick_o.kind  = wstq_pkg::SRC_GLOBAL;
      pick_o.ring  = VW'(NUM_WORKER_QUEUES);
    end else begin
      for (int d = 1; d < NUM_WORKER_QUEUES; d++) begin
        v = wk + VW'(d);
        if (v >= VW'(NUM_WORKER_QUEUES)) begin
          v = v - VW'(NUM_WORKER_QUEUES);
        end
        if (!pick_o.found && (VW'(d) <= limit) && nonempty_i[v[RW-1:0]]) begin
          pick_o.found = 1'b1;
          pick_o.kind  = wstq_pkg::SRC_STOLEN;
          pick_o.ring  = v;
        end
      end
    end
  end

endmodule

// ===== rtl/work_stealing_task_queues.sv =====
`timescale 1ns / 1ps
// Latency: a result is strobed on done_o in the cycle after its request is taken.
// Throughput: one request per cycle; busy_o stays low, the task store has separate
// write and registered read ports and each request uses at most one of them.
// The receiver cannot stall, so no result is ever held back.
// Reset clears ring pointers and counts and sets steal_tries to 4; the store is not cleared.
module work_stealing_task_queues #(
  parameter int NUM_WORKER_QUEUES = wstq_pkg::NUM_WORKER_QUEUES_DEF,
  parameter int QUEUE_DEPTH       = wstq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  wstq_pkg::req_t                  req_i,
  output logic                            done_o,
  output wstq_pkg::rsp_t                  rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wstq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wstq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wstq_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int NUM_RINGS = NUM_WORKER_QUEUES + 1;
  localparam int RW        = $clog2(NUM_RINGS);
  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_RINGS * QUEUE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic [PW-1:0]   head_q  [NUM_RINGS];
  logic [PW-1:0]   tail_q  [NUM_RINGS];
  logic [CW-1:0]   count_q [NUM_RINGS];
  logic [2:0]      steal_q;
  logic [31:0]     mem     [MEM_DEPTH];
  logic [31:0]     rd_data_q;
  logic            done_q;
  wstq_pkg::rsp_t  rsp_q;
  wstq_pkg::rsp_t  rsp_d;

  logic [NUM_RINGS-1:0] nonempty;
  wstq_pkg::pick_t      pick;
  logic                 accept;
  logic                 is_pop;
  logic                 push_sel_ok;
  logic [RW-1:0]        push_idx;
  logic                 push_full;
  logic [RW-1:0]        pop_idx;
  logic                 wr_en;
  logic                 rd_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic                 cfg_wr;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [RW-1:0] r, input logic [PW-1:0] p);
    slot_addr = AW'(int'(r) * QUEUE_DEPTH + int'(p));
  endfunction

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign is_pop = (req_i.operation == wstq_pkg::OP_POP);

  // Flag rings that hold at least one task
  always_comb begin
    for (int r = 0; r < NUM_RINGS; r++) begin
      nonempty[r] = (count_q[r] != '0);
    end
  end

  wstq_pick #(
    .NUM_WORKER_QUEUES(NUM_WORKER_QUEUES)
  ) u_pick (
    .nonempty_i   (nonempty),
    .worker_i     (req_i.worker),
    .steal_tries_i(steal_q),
    .pick_o       (pick)
  );

  // Decode the push target and its room
  assign push_sel_ok = (int'(req_i.queue_select) < NUM_RINGS);
  assign push_idx    = push_sel_ok ? RW'(req_i.queue_select) : '0;
  assign push_full   = (count_q[push_idx] >= CW'(QUEUE_DEPTH));
  assign pop_idx     = pick.ring[RW-1:0];

  assign wr_en   = accept && !is_pop && push_sel_ok && !push_full;
  assign rd_en   = accept && is_pop && pick.found;
  assign wr_addr = slot_addr(push_idx, tail_q[push_idx]);
  assign rd_addr = slot_addr(pop_idx, head_q[pop_idx]);

  // Task store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= req_i.task_id;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Advance ring pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_RINGS; r++) begin
        head_q[r]  <= '0;
        tail_q[r]  <= '0;
        count_q[r] <= '0;
      end
    end else begin
      if (wr_en) begin
        tail_q[push_idx]  <= next_slot(tail_q[push_idx]);
        count_q[push_idx] <= count_q[push_idx] + CW'(1);
      end
      if (rd_en) begin
        head_q[pop_idx]  <= next_slot(head_q[pop_idx]);
        count_q[pop_idx] <= count_q[pop_idx] - CW'(1);
      end
    end
  end

  // Build the result fields known at acceptance
  always_comb begin
    rsp_d              = '0;
    rsp_d.source_kind  = wstq_pkg::SRC_NONE;
    if (is_pop) begin
      rsp_d.found        = pick.found;
      rsp_d.source_kind  = pick.kind;
      rsp_d.source_queue = 4'(pick.ring);
    end else begin
      rsp_d.overflow = push_sel_ok && push_full;
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o             = done_q;
  assign rsp_o.found        = rsp_q.found;
  assign rsp_o.popped_id    = rsp_q.found ? rd_data_q : '0;
  assign rsp_o.source_kind  = rsp_q.source_kind;
  assign rsp_o.source_queue = rsp_q.source_queue;
  assign rsp_o.overflow     = rsp_q.overflow;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steal_q <= wstq_pkg::STEAL_TRIES_RESET;
    end else if (cfg_wr && (paddr[2] == wstq_pkg::REG_STEAL_TRIES)) begin
      steal_q <= pwdata[2:0];
    end
  end

  assign prdata = (paddr[2] == wstq_pkg::REG_STEAL_TRIES) ?
                  wstq_pkg::APB_DATA_W'(steal_q) : '0;

endmodule

// ===== rtl/wstq_checker.sv =====
`timescale 1ns / 1ps

module wstq_checker #(
  parameter int NUM_WORKER_QUEUES = wstq_pkg::NUM_WORKER_QUEUES_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input wstq_pkg::req_t req_i,
  input logic           done_o,
  input wstq_pkg::rsp_t rsp_o
);

  // Every transaction yields exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("missing result strobe");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result strobe without transaction");

  // A push never reports a popped task
  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_i.operation == wstq_pkg::OP_PUSH)) |=>
      (!rsp_o.found && (rsp_o.source_kind == wstq_pkg::SRC_NONE)))
    else $error("push result carries a pop");

  // An empty pop and an overflow report zero fields
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.found) |->
      ((rsp_o.popped_id == '0) && (rsp_o.source_queue == '0) &&
       (rsp_o.source_kind == wstq_pkg::SRC_NONE)))
    else $error("nonzero fields without a found task");

  // Global source is reported as the global ring number
  a_global_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.source_kind == wstq_pkg::SRC_GLOBAL)) |->
      ((rsp_o.source_queue == 4'(NUM_WORKER_QUEUES)) && rsp_o.found && !rsp_o.overflow))
    else $error("bad global source report");

endmodule

bind work_stealing_task_queues wstq_checker #(
  .NUM_WORKER_QUEUES(NUM_WORKER_QUEUES)
) u_wstq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
